### rtl/ctd_pkg.sv
// ----------------------------------------------------------------------------
// ctd_pkg
// Shared types, codes and helpers of the chunked transfer decoder.
// ----------------------------------------------------------------------------
package ctd_pkg;

    // default width of the chunk size counters
    localparam int LEN_BITS_DEFAULT = 32;

    // width of the max_chunk_len register
    localparam int CFG_BITS = 32;
    localparam logic [CFG_BITS-1:0] MAX_CHUNK_LEN_RESET = '1;

    // special characters of the size line
    localparam logic [7:0] CH_CR = 8'h0D;
    localparam logic [7:0] CH_LF = 8'h0A;
    localparam logic [7:0] CH_SP = 8'h20;

    // result kinds
    typedef enum logic [1:0] {
        KIND_DATA  = 2'd0,
        KIND_LAST  = 2'd1,
        KIND_DONE  = 2'd2,
        KIND_ERROR = 2'd3
    } kind_t;

    // error codes
    typedef enum logic [1:0] {
        ERR_NONE      = 2'd0,
        ERR_NO_DIGITS = 2'd1,
        ERR_TOO_LARGE = 2'd2,
        ERR_NO_CRLF   = 2'd3
    } err_t;

    // one input transaction
    typedef struct packed {
        logic [7:0] in_byte;
        logic       new_body;
    } in_item_t;

    // one result transaction
    typedef struct packed {
        logic [7:0] out_byte;
        kind_t      kind;
        err_t       error_code;
    } result_t;

    // hex character decode: {is_hex, value}
    function automatic logic [4:0] hex_digit(input logic [7:0] c);
        logic [4:0] r;
        r = 5'b0;
        if (c >= 8'h30 && c <= 8'h39)
        begin
            r = {1'b1, 4'(c - 8'h30)};
        end
        else if (c >= 8'h41 && c <= 8'h46)
        begin
            r = {1'b1, 4'(c - 8'h37)};
        end
        else if (c >= 8'h61 && c <= 8'h66)
        begin
            r = {1'b1, 4'(c - 8'h57)};
        end
        return r;
    endfunction

endpackage

### rtl/ctd_if.sv
// ----------------------------------------------------------------------------
// ctd_if
// Valid/ready stream interfaces for the decoder's input and result channels.
// ----------------------------------------------------------------------------

// body byte channel
interface ctd_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;
    logic       new_body;

    modport source (output valid, output in_byte, output new_body, input ready);
    modport sink   (input valid, input in_byte, input new_body, output ready);
endinterface

// decoded result channel
interface ctd_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic [1:0] kind;
    logic [1:0] error_code;

    modport source (output valid, output out_byte, output kind, output error_code,
                    input ready);
    modport sink   (input valid, input out_byte, input kind, input error_code,
                    output ready);
endinterface

### rtl/ctd_in_stage.sv
// ----------------------------------------------------------------------------
// ctd_in_stage
// Input register: holds one body byte until the decode step takes it.
// ----------------------------------------------------------------------------
module ctd_in_stage
(
    input  logic               clk,
    input  logic               rst_n,
    ctd_in_if.sink             in_ch,
    input  logic               can_take,
    output logic               step,
    output ctd_pkg::in_item_t  item
);

    logic               valid_reg;
    ctd_pkg::in_item_t  item_reg;
    logic               load;

    // take a transaction when empty or when the held one moves on
    assign step        = valid_reg && can_take;
    assign in_ch.ready = !valid_reg || can_take;
    assign load        = in_ch.valid && in_ch.ready;
    assign item        = item_reg;

    // valid flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (load)
        begin
            valid_reg <= 1'b1;
        end
        else if (step)
        begin
            valid_reg <= 1'b0;
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            item_reg.in_byte  <= in_ch.in_byte;
            item_reg.new_body <= in_ch.new_body;
        end
    end

endmodule

### rtl/ctd_decode.sv
// ----------------------------------------------------------------------------
// ctd_decode
// Chunk decode state: size line parsing, data countdown and CRLF check,
// plus the max_chunk_len register.
// ----------------------------------------------------------------------------
module ctd_decode #(
    parameter int LEN_BITS = ctd_pkg::LEN_BITS_DEFAULT
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_wr_en,
    input  logic [ctd_pkg::CFG_BITS-1:0]  cfg_wr_data,
    input  logic                          step,
    input  ctd_pkg::in_item_t             item,
    output logic                          res_valid,
    output ctd_pkg::result_t              result
);

    localparam int CMP_W = (LEN_BITS > ctd_pkg::CFG_BITS) ? LEN_BITS : ctd_pkg::CFG_BITS;

    typedef enum logic [5:0] {
        PH_SIZE = 6'b000001,
        PH_DATA = 6'b000010,
        PH_CR   = 6'b000100,
        PH_LF   = 6'b001000,
        PH_DONE = 6'b010000,
        PH_ERR  = 6'b100000
    } phase_t;

    phase_t                       phase_reg, phase_next, phase_cur;
    logic                         saw_cr_reg, saw_cr_next, saw_cr_cur;
    logic                         in_ext_reg, in_ext_next, in_ext_cur;
    logic                         digit_seen_reg, digit_seen_next, digit_seen_cur;
    logic [LEN_BITS-1:0]          size_accum_reg, size_accum_next, size_accum_cur;
    logic [LEN_BITS-1:0]          bytes_left_reg, bytes_left_next, bytes_left_cur;
    logic [ctd_pkg::CFG_BITS-1:0] max_len_reg;
    logic [4:0]                   hex;
    logic                         emit;
    logic [7:0]                   c;

    assign c         = item.in_byte;
    assign hex       = ctd_pkg::hex_digit(c);
    assign res_valid = step && emit;

    // next state and result for the held byte
    always_comb
    begin
        // new_body restarts at a size line before this byte
        phase_cur      = item.new_body ? PH_SIZE : phase_reg;
        saw_cr_cur     = item.new_body ? 1'b0 : saw_cr_reg;
        in_ext_cur     = item.new_body ? 1'b0 : in_ext_reg;
        digit_seen_cur = item.new_body ? 1'b0 : digit_seen_reg;
        size_accum_cur = item.new_body ? '0 : size_accum_reg;
        bytes_left_cur = item.new_body ? '0 : bytes_left_reg;

        phase_next      = phase_cur;
        saw_cr_next     = saw_cr_cur;
        in_ext_next     = in_ext_cur;
        digit_seen_next = digit_seen_cur;
        size_accum_next = size_accum_cur;
        bytes_left_next = bytes_left_cur;

        emit              = 1'b0;
        result.out_byte   = 8'h00;
        result.kind       = ctd_pkg::KIND_DATA;
        result.error_code = ctd_pkg::ERR_NONE;

        case (phase_cur)
            PH_SIZE:
            begin
                if (saw_cr_cur)
                begin
                    if (c == ctd_pkg::CH_LF)
                    begin
                        // end of size line
                        saw_cr_next     = 1'b0;
                        in_ext_next     = 1'b0;
                        digit_seen_next = 1'b0;
                        size_accum_next = '0;
                        if (!digit_seen_cur)
                        begin
                            emit              = 1'b1;
                            result.kind       = ctd_pkg::KIND_ERROR;
                            result.error_code = ctd_pkg::ERR_NO_DIGITS;
                            phase_next        = PH_ERR;
                        end
                        else if (size_accum_cur == {LEN_BITS{1'b1}} ||
                                 CMP_W'(size_accum_cur) > CMP_W'(max_len_reg))
                        begin
                            emit              = 1'b1;
                            result.kind       = ctd_pkg::KIND_ERROR;
                            result.error_code = ctd_pkg::ERR_TOO_LARGE;
                            phase_next        = PH_ERR;
                        end
                        else if (size_accum_cur == '0)
                        begin
                            emit        = 1'b1;
                            result.kind = ctd_pkg::KIND_DONE;
                            phase_next  = PH_DONE;
                        end
                        else
                        begin
                            bytes_left_next = size_accum_cur;
                            phase_next      = PH_DATA;
                        end
                    end
                    else
                    begin
                        // stray cr: rest of line ignored, another cr keeps waiting
                        in_ext_next = 1'b1;
                        if (c != ctd_pkg::CH_CR)
                        begin
                            saw_cr_next = 1'b0;
                        end
                    end
                end
                else if (c == ctd_pkg::CH_CR)
                begin
                    saw_cr_next = 1'b1;
                end
                else if (in_ext_cur)
                begin
                    in_ext_next = 1'b1;
                end
                else if (c == ctd_pkg::CH_SP && !digit_seen_cur)
                begin
                    digit_seen_next = 1'b0;
                end
                else if (!hex[4])
                begin
                    in_ext_next = 1'b1;
                end
                else
                begin
                    // accumulate a digit, saturating on overflow
                    digit_seen_next = 1'b1;
                    if (size_accum_cur[LEN_BITS-1 -: 4] != 4'h0)
                    begin
                        size_accum_next = '1;
                    end
                    else
                    begin
                        size_accum_next = {size_accum_cur[LEN_BITS-5:0], hex[3:0]};
                    end
                end
            end
            PH_DATA:
            begin
                emit            = 1'b1;
                result.out_byte = c;
                bytes_left_next = bytes_left_cur - LEN_BITS'(1);
                if (bytes_left_cur == LEN_BITS'(1))
                begin
                    result.kind = ctd_pkg::KIND_LAST;
                    phase_next  = PH_CR;
                end
            end
            PH_CR:
            begin
                if (c != ctd_pkg::CH_CR)
                begin
                    emit              = 1'b1;
                    result.kind       = ctd_pkg::KIND_ERROR;
                    result.error_code = ctd_pkg::ERR_NO_CRLF;
                    phase_next        = PH_ERR;
                end
                else
                begin
                    phase_next = PH_LF;
                end
            end
            PH_LF:
            begin
                if (c != ctd_pkg::CH_LF)
                begin
                    emit              = 1'b1;
                    result.kind       = ctd_pkg::KIND_ERROR;
                    result.error_code = ctd_pkg::ERR_NO_CRLF;
                    phase_next        = PH_ERR;
                end
                else
                begin
                    phase_next      = PH_SIZE;
                    saw_cr_next     = 1'b0;
                    in_ext_next     = 1'b0;
                    digit_seen_next = 1'b0;
                    size_accum_next = '0;
                end
            end
            default:
            begin
                // done or error: bytes dropped until new_body
                emit = 1'b0;
            end
        endcase
    end

    // decode state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= PH_SIZE;
            saw_cr_reg     <= 1'b0;
            in_ext_reg     <= 1'b0;
            digit_seen_reg <= 1'b0;
            size_accum_reg <= '0;
            bytes_left_reg <= '0;
        end
        else if (step)
        begin
            phase_reg      <= phase_next;
            saw_cr_reg     <= saw_cr_next;
            in_ext_reg     <= in_ext_next;
            digit_seen_reg <= digit_seen_next;
            size_accum_reg <= size_accum_next;
            bytes_left_reg <= bytes_left_next;
        end
    end

    // size limit register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_len_reg <= ctd_pkg::MAX_CHUNK_LEN_RESET;
        end
        else if (cfg_wr_en)
        begin
            max_len_reg <= cfg_wr_data;
        end
    end

    // last data byte leads to the trailing cr check
    a_last_to_cr: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && result.kind == ctd_pkg::KIND_LAST |=> phase_reg == PH_CR)
        else $error("last data byte did not move to cr check");

    // an error result parks the decoder
    a_error_parks: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && result.kind == ctd_pkg::KIND_ERROR |=> phase_reg == PH_ERR)
        else $error("error result without error phase");

    // a data phase always has bytes left to pass
    a_data_count: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg == PH_DATA |-> bytes_left_reg != '0)
        else $error("data phase with zero bytes left");

    // halted decoder stays quiet until a new body
    a_halted_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        step && !item.new_body && (phase_reg == PH_DONE || phase_reg == PH_ERR)
        |-> !res_valid)
        else $error("result produced after completion or error");

endmodule

### rtl/ctd_out_stage.sv
// ----------------------------------------------------------------------------
// ctd_out_stage
// Result register with a skid entry, so the decode side sees a registered
// space flag and never waits on the sink's ready in the same cycle.
// ----------------------------------------------------------------------------
module ctd_out_stage
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  ctd_pkg::result_t  result,
    output logic              can_take,
    ctd_out_if.source         out_ch
);

    logic              main_valid_reg;
    logic              skid_valid_reg;
    ctd_pkg::result_t  main_reg;
    ctd_pkg::result_t  skid_reg;
    logic              pop;

    assign pop      = main_valid_reg && out_ch.ready;
    assign can_take = !skid_valid_reg;

    assign out_ch.valid      = main_valid_reg;
    assign out_ch.out_byte   = main_reg.out_byte;
    assign out_ch.kind       = main_reg.kind;
    assign out_ch.error_code = main_reg.error_code;

    // occupancy
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            main_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (skid_valid_reg)
        begin
            if (pop)
            begin
                skid_valid_reg <= 1'b0;
            end
        end
        else if (!main_valid_reg || pop)
        begin
            main_valid_reg <= push;
        end
        else if (push)
        begin
            skid_valid_reg <= 1'b1;
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        if (skid_valid_reg)
        begin
            if (pop)
            begin
                main_reg <= skid_reg;
            end
        end
        else if (!main_valid_reg || pop)
        begin
            main_reg <= result;
        end
        else if (push)
        begin
            skid_reg <= result;
        end
    end

endmodule

### rtl/chunked_transfer_decoder_unit.sv
// ----------------------------------------------------------------------------
// chunked_transfer_decoder_unit
// HTTP/1.1 chunked body decoder, one body byte per transaction.
//
//   channel   dir  handshake      payload
//   in_ch     in   valid/ready    in_byte[7:0], new_body
//   out_ch    out  valid/ready    out_byte[7:0], kind[1:0], error_code[1:0]
//   cfg       in   cfg_wr_en      cfg_wr_data[31:0] -> max_chunk_len
//
// One byte per cycle while the skid entry has space; a byte is held in the input
// register, then its result is registered in the result register.
// The decode step is a single pass of compare/shift/decrement logic per byte.
// Reset clears the decode state and sets max_chunk_len to all ones.
// A two-entry result stage keeps input ready off the sink's ready; a stalled
// sink stops intake once both result entries and the input register are full.
// ----------------------------------------------------------------------------
module chunked_transfer_decoder_unit #(
    parameter int LEN_BITS = ctd_pkg::LEN_BITS_DEFAULT
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_wr_en,
    input  logic [ctd_pkg::CFG_BITS-1:0]  cfg_wr_data,
    ctd_in_if.sink                        in_ch,
    ctd_out_if.source                     out_ch
);

    logic               can_take;
    logic               step;
    logic               res_valid;
    ctd_pkg::in_item_t  item;
    ctd_pkg::result_t   result;

    // input register
    ctd_in_stage u_in_stage (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_ch    (in_ch),
        .can_take (can_take),
        .step     (step),
        .item     (item)
    );

    // decode step
    ctd_decode #(
        .LEN_BITS (LEN_BITS)
    ) u_decode (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .step        (step),
        .item        (item),
        .res_valid   (res_valid),
        .result      (result)
    );

    // result register
    ctd_out_stage u_out_stage (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (res_valid),
        .result   (result),
        .can_take (can_take),
        .out_ch   (out_ch)
    );

endmodule

### tb/tb_chunked_transfer_decoder_unit.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_chunked_transfer_decoder_unit
// Self-checking bench for the chunked body decoder. A directed burst covers
// leading spaces, data byte extremes, the last-byte mark, body complete, the
// ignored bytes after completion and after an error, a size line with no hex
// digits, a stray CR in a size line and a missing CRLF after data. Random
// bodies with random sizes, extensions, leading zeros, oversized and
// overflowing size lines, broken trailers and noise follow. Each phase runs
// under a set chunk size limit and mix of sender gaps and receiver
// stalls. A scoreboard class predicts every result from the accepted bytes.
// ----------------------------------------------------------------------------
module tb_chunked_transfer_decoder_unit;

    localparam int LEN_W = ctd_pkg::LEN_BITS_DEFAULT;
    localparam logic [LEN_W-1:0] SAT_EDGE = {LEN_W{1'b1}} >> 4;
    localparam int NUM_PHASES = 7;
    localparam int BYTES_PER_PHASE = 70;
    localparam int SETTLE_CYCLES = 8;

    // decoder states tracked by the predictor
    typedef enum logic [5:0] {
        ST_SIZE = 6'b000001,
        ST_DATA = 6'b000010,
        ST_CR   = 6'b000100,
        ST_LF   = 6'b001000,
        ST_DONE = 6'b010000,
        ST_ERR  = 6'b100000
    } dec_state_t;

    // predicts decoder results and checks them in order
    class chunk_scoreboard;
        logic [ctd_pkg::CFG_BITS-1:0] max_len;
        dec_state_t                   state;
        bit                           saw_cr;
        bit                           in_ext;
        bit                           digit_seen;
        logic [LEN_W-1:0]             size_acc;
        logic [LEN_W-1:0]             remaining;
        ctd_pkg::result_t             pending_results[$];
        int                           errors;
        int                           kind_seen[4];
        int                           code_seen[4];

        function new();
            max_len = ctd_pkg::MAX_CHUNK_LEN_RESET;
            state = ST_SIZE;
            clear_line();
            remaining = '0;
            errors = 0;
            foreach (kind_seen[i])
            begin
                kind_seen[i] = 0;
                code_seen[i] = 0;
            end
        endfunction

        function void clear_line();
            saw_cr = 1'b0;
            in_ext = 1'b0;
            digit_seen = 1'b0;
            size_acc = '0;
        endfunction

        function void push(logic [7:0] b, ctd_pkg::kind_t k, ctd_pkg::err_t e);
            ctd_pkg::result_t r;
            r.out_byte = b;
            r.kind = k;
            r.error_code = e;
            pending_results.push_back(r);
        endfunction

        function void flag_error(ctd_pkg::err_t e);
            state = ST_ERR;
            push(8'h00, ctd_pkg::KIND_ERROR, e);
        endfunction

        // advance the decoder by one accepted byte
        function void decode_byte(logic [7:0] c, logic restart);
            logic [3:0]       nib;
            bit               is_hex;
            logic [LEN_W-1:0] n;
            bit               any;
            if (restart)
            begin
                state = ST_SIZE;
                clear_line();
                remaining = '0;
            end
            case (state)
                ST_SIZE:
                begin
                    if (saw_cr)
                    begin
                        if (c == ctd_pkg::CH_LF)
                        begin
                            // end of size line
                            n = size_acc;
                            any = digit_seen;
                            clear_line();
                            if (!any)
                                flag_error(ctd_pkg::ERR_NO_DIGITS);
                            else if (n == '1 || n > max_len)
                                flag_error(ctd_pkg::ERR_TOO_LARGE);
                            else if (n == '0)
                            begin
                                state = ST_DONE;
                                push(8'h00, ctd_pkg::KIND_DONE, ctd_pkg::ERR_NONE);
                            end
                            else
                            begin
                                remaining = n;
                                state = ST_DATA;
                            end
                        end
                        else
                        begin
                            // stray CR: rest of line ignored, another CR keeps waiting
                            in_ext = 1'b1;
                            if (c != ctd_pkg::CH_CR)
                                saw_cr = 1'b0;
                        end
                    end
                    else if (c == ctd_pkg::CH_CR)
                        saw_cr = 1'b1;
                    else if (in_ext)
                        ;
                    else if (c == ctd_pkg::CH_SP && !digit_seen)
                        ;
                    else
                    begin
                        is_hex = 1'b1;
                        nib = 4'h0;
                        if (c >= "0" && c <= "9")
                            nib = 4'(c - "0");
                        else if (c >= "A" && c <= "F")
                            nib = 4'(c - "A" + 8'd10);
                        else if (c >= "a" && c <= "f")
                            nib = 4'(c - "a" + 8'd10);
                        else
                            is_hex = 1'b0;
                        if (!is_hex)
                            in_ext = 1'b1;
                        else
                        begin
                            digit_seen = 1'b1;
                            // saturate once the size no longer fits
                            if (size_acc > SAT_EDGE)
                                size_acc = '1;
                            else
                                size_acc = (size_acc << 4) | LEN_W'(nib);
                        end
                    end
                end
                ST_DATA:
                begin
                    remaining = remaining - 1'b1;
                    if (remaining == '0)
                    begin
                        state = ST_CR;
                        push(c, ctd_pkg::KIND_LAST, ctd_pkg::ERR_NONE);
                    end
                    else
                        push(c, ctd_pkg::KIND_DATA, ctd_pkg::ERR_NONE);
                end
                ST_CR:
                begin
                    if (c != ctd_pkg::CH_CR)
                        flag_error(ctd_pkg::ERR_NO_CRLF);
                    else
                        state = ST_LF;
                end
                ST_LF:
                begin
                    if (c != ctd_pkg::CH_LF)
                        flag_error(ctd_pkg::ERR_NO_CRLF);
                    else
                    begin
                        state = ST_SIZE;
                        clear_line();
                    end
                end
                default:
                    ;
            endcase
        endfunction

        // compare one result transaction with the oldest prediction
        function void check_result(ctd_pkg::result_t got);
            ctd_pkg::result_t want;
            if (pending_results.size() == 0)
            begin
                if (errors < 10)
                    $display("unexpected result: byte %02h kind %0d code %0d",
                             got.out_byte, got.kind, got.error_code);
                errors++;
                return;
            end
            want = pending_results.pop_front();
            kind_seen[want.kind]++;
            code_seen[want.error_code]++;
            if (got.out_byte !== want.out_byte || got.kind !== want.kind ||
                got.error_code !== want.error_code)
            begin
                if (errors < 10)
                    $display({"mismatch: expected byte %02h kind %s code %s, ",
                              "got byte %02h kind %0d code %0d"},
                             want.out_byte, want.kind.name(), want.error_code.name(),
                             got.out_byte, got.kind, got.error_code);
                errors++;
            end
        endfunction
    endclass

    logic                         clk;
    logic                         rst_n;
    logic                         cfg_wr_en;
    logic [ctd_pkg::CFG_BITS-1:0] cfg_wr_data;

    ctd_in_if  in_ch();
    ctd_out_if out_ch();

    chunk_scoreboard              sb;
    int                           send_idle_pct = 0;
    int                           recv_stall_pct = 0;
    int                           body_bytes = 0;
    bit                           tally_on = 1'b1;
    logic [ctd_pkg::CFG_BITS-1:0] cur_limit = ctd_pkg::MAX_CHUNK_LEN_RESET;

    chunked_transfer_decoder_unit i_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .in_ch       (in_ch),
        .out_ch      (out_ch)
    );

    // clock
    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // receiver stalls
    always @(posedge clk)
    begin
        out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // monitor both channels
    always @(posedge clk)
    begin
        ctd_pkg::result_t r;
        if (rst_n === 1'b1)
        begin
            if (out_ch.valid && out_ch.ready)
            begin
                r.out_byte = out_ch.out_byte;
                r.kind = ctd_pkg::kind_t'(out_ch.kind);
                r.error_code = ctd_pkg::err_t'(out_ch.error_code);
                sb.check_result(r);
            end
            if (in_ch.valid && in_ch.ready)
                sb.decode_byte(in_ch.in_byte, in_ch.new_body);
        end
    end

    // one input transaction, with random sender gaps
    task automatic send_byte(input logic [7:0] b, input bit nb);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_ch.valid <= 1'b0;
            @(posedge clk);
        end
        in_ch.valid <= 1'b1;
        in_ch.in_byte <= b;
        in_ch.new_body <= nb;
        @(posedge clk);
        while (!in_ch.ready)
            @(posedge clk);
        if (tally_on)
            body_bytes++;
    endtask

    task automatic send_text(input string s, input bit nb);
        for (int i = 0; i < s.len(); i++)
            send_byte(s[i], nb && i == 0);
    endtask

    task automatic send_line(input string s, input bit nb);
        send_text(s, nb);
        send_byte(ctd_pkg::CH_CR, nb && s.len() == 0);
        send_byte(ctd_pkg::CH_LF, 1'b0);
    endtask

    // size line with optional spaces, leading zeros, extension and stray CR
    task automatic send_size_line(input logic [31:0] value, input bit overflow,
                                  input bit nb);
        logic [7:0] size_chars[$];
        logic [3:0] nib;
        logic [7:0] c;
        int         ndig;
        bit         upper;
        if ($urandom_range(3) == 0)
            repeat ($urandom_range(1, 2)) size_chars.push_back(ctd_pkg::CH_SP);
        if (overflow)
            ndig = $urandom_range(9, 11);
        else
        begin
            ndig = 1;
            while (ndig < 8 && (value >> (4 * ndig)) != 0)
                ndig++;
            if ($urandom_range(4) == 0)
                ndig += $urandom_range(1, 2);
        end
        for (int k = ndig - 1; k >= 0; k--)
        begin
            if (overflow)
                nib = (k == ndig - 1) ? 4'($urandom_range(1, 15)) : 4'($urandom_range(15));
            else
                nib = 4'(value >> (4 * k));
            upper = $urandom_range(1);
            c = (nib < 4'd10) ? 8'h30 + nib : (upper ? 8'h41 : 8'h61) + nib - 8'd10;
            size_chars.push_back(c);
        end
        // chunk extension, any bytes but CR
        if ($urandom_range(3) == 0)
        begin
            size_chars.push_back($urandom_range(1) ? 8'h3B : ctd_pkg::CH_SP);
            repeat ($urandom_range(0, 3))
            begin
                c = 8'($urandom_range(255));
                if (c == ctd_pkg::CH_CR)
                    c = 8'h3B;
                size_chars.push_back(c);
            end
        end
        // stray CR not followed by LF
        if ($urandom_range(7) == 0)
        begin
            size_chars.push_back(ctd_pkg::CH_CR);
            size_chars.push_back($urandom_range(1) ? ctd_pkg::CH_CR : 8'h78);
        end
        size_chars.push_back(ctd_pkg::CH_CR);
        size_chars.push_back(ctd_pkg::CH_LF);
        foreach (size_chars[i])
            send_byte(size_chars[i], nb && i == 0);
    endtask

    // one random body: a few chunks then a zero line, sometimes broken
    task automatic send_body();
        bit          first;
        bit          broken;
        bit          overflow;
        int          pick;
        int          r;
        logic [31:0] sz;
        logic [31:0] span;
        logic [7:0]  bad;
        string       junk;
        first = 1'b1;
        broken = 1'b0;
        for (int i = $urandom_range(0, 3); i > 0 && !broken; i--)
        begin
            pick = $urandom_range(99);
            overflow = 1'b0;
            sz = 32'd0;
            if (pick < 70)
                sz = $urandom_range(1, 6);
            else if (pick < 82)
                sz = $urandom_range(7, 24);
            else if (pick < 90)
            begin
                if (cur_limit == '1)
                    sz = '1;
                else
                begin
                    span = '1 - cur_limit;
                    sz = cur_limit + 1 + ($urandom % span);
                end
            end
            else if (pick < 95)
                overflow = 1'b1;
            else
            begin
                // size line without hex digits
                case ($urandom_range(3))
                    0: junk = "";
                    1: junk = "  ";
                    2: junk = "g7";
                    default: junk = " ;a";
                endcase
                send_line(junk, first);
                broken = 1'b1;
                continue;
            end
            send_size_line(sz, overflow, first);
            first = 1'b0;
            if (overflow || sz == '1 || sz > cur_limit)
                broken = 1'b1;
            else if ($urandom_range(19) == 0)
            begin
                // abandoned mid-chunk, next body restarts
                repeat ($urandom_range(0, int'(sz) - 1))
                    send_byte(8'($urandom_range(255)), 1'b0);
                broken = 1'b1;
            end
            else
            begin
                repeat (int'(sz))
                    send_byte(8'($urandom_range(255)), 1'b0);
                r = $urandom_range(24);
                bad = 8'($urandom_range(255));
                if (r == 0)
                begin
                    if (bad == ctd_pkg::CH_CR)
                        bad = 8'h00;
                    send_byte(bad, 1'b0);
                    broken = 1'b1;
                end
                else if (r == 1)
                begin
                    if (bad == ctd_pkg::CH_LF)
                        bad = 8'hFF;
                    send_byte(ctd_pkg::CH_CR, 1'b0);
                    send_byte(bad, 1'b0);
                    broken = 1'b1;
                end
                else
                begin
                    send_byte(ctd_pkg::CH_CR, 1'b0);
                    send_byte(ctd_pkg::CH_LF, 1'b0);
                end
            end
        end
        if (!broken)
            send_size_line(32'd0, 1'b0, first);
        // noise between bodies, not counted
        if ($urandom_range(9) == 0)
        begin
            tally_on = 1'b0;
            repeat ($urandom_range(1, 4))
                send_byte(8'($urandom_range(255)), $urandom_range(3) == 0);
            tally_on = 1'b1;
        end
    endtask

    // let every expected result arrive, then let the pipeline settle
    task automatic wait_idle();
        in_ch.valid <= 1'b0;
        while (sb.pending_results.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_limit(input logic [ctd_pkg::CFG_BITS-1:0] v);
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= v;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        sb.max_len = v;
        cur_limit = v;
    endtask

    // main sequence
    initial
    begin
        logic [ctd_pkg::CFG_BITS-1:0] lim;
        int                           goal;
        int                           leftover;
        sb = new();
        rst_n <= 1'b0;
        cfg_wr_en <= 1'b0;
        cfg_wr_data <= '0;
        in_ch.valid <= 1'b0;
        in_ch.in_byte <= 8'h00;
        in_ch.new_body <= 1'b0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int p = 0; p < NUM_PHASES; p++)
        begin
            case (p)
                0:
                begin
                    lim = ctd_pkg::MAX_CHUNK_LEN_RESET;
                    send_idle_pct = 0;
                    recv_stall_pct = 0;
                end
                1:
                begin
                    lim = '1;
                    send_idle_pct = 0;
                    recv_stall_pct = 0;
                end
                2:
                begin
                    lim = '0;
                    send_idle_pct = 51;
                    recv_stall_pct = 0;
                end
                3:
                begin
                    lim = 32'd5;
                    send_idle_pct = 0;
                    recv_stall_pct = 51;
                end
                4:
                begin
                    lim = 32'd16;
                    send_idle_pct = 15;
                    recv_stall_pct = 15;
                end
                5:
                begin
                    lim = $urandom_range(1, 40);
                    send_idle_pct = 0;
                    recv_stall_pct = 0;
                end
                default:
                begin
                    lim = 32'hFFFF_FFFE;
                    send_idle_pct = 0;
                    recv_stall_pct = 51;
                end
            endcase
            if (p > 0)
            begin
                wait_idle();
                write_limit(lim);
            end
            if (p == 0)
            begin
                // leading space, data extremes, last byte mark
                send_line(" 2", 1'b0);
                send_byte(8'h00, 1'b0);
                send_byte(8'hFF, 1'b0);
                send_byte(ctd_pkg::CH_CR, 1'b0);
                send_byte(ctd_pkg::CH_LF, 1'b0);
                // body complete, then a byte that is ignored
                send_line("0", 1'b0);
                send_byte(8'hFF, 1'b0);
                // non-hex before digits
                send_line("x", 1'b1);
                // stray CR in the size line, then missing CRLF after data
                send_text("1", 1'b1);
                send_byte(ctd_pkg::CH_CR, 1'b0);
                send_text("A", 1'b0);
                send_byte(ctd_pkg::CH_CR, 1'b0);
                send_line("", 1'b0);
                send_byte(8'h80, 1'b0);
                send_byte(8'h51, 1'b0);
                // ignored after the error
                send_byte(ctd_pkg::CH_CR, 1'b0);
            end
            goal = body_bytes + BYTES_PER_PHASE;
            while (body_bytes < goal)
                send_body();
        end
        wait_idle();

        leftover = sb.pending_results.size();
        if (leftover != 0)
            $display("%0d expected results never arrived", leftover);
        $display("%0d body bytes sent over %0d limit settings with mixed gaps and stalls",
                 body_bytes, NUM_PHASES);
        $display({"results: %0d data, %0d last, %0d complete, ",
                  "errors %0d/%0d/%0d (digits/size/crlf)"},
                 sb.kind_seen[ctd_pkg::KIND_DATA], sb.kind_seen[ctd_pkg::KIND_LAST],
                 sb.kind_seen[ctd_pkg::KIND_DONE],
                 sb.code_seen[ctd_pkg::ERR_NO_DIGITS], sb.code_seen[ctd_pkg::ERR_TOO_LARGE],
                 sb.code_seen[ctd_pkg::ERR_NO_CRLF]);
        if (sb.errors == 0 && leftover == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

    // watchdog
    initial
    begin
        #2_400_000;
        $display("timeout: decoder stopped making progress");
        $display("Regression FAIL");
        $finish;
    end

endmodule
